### src/gmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid maze DFS stepper package
// Shared constants, cell codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gmd_pkg;

   localparam int ROWS = 32;
   localparam int COLS = 32;

   // Cell coordinates are 5 bits wide, so the usable grid is capped at 32 x 32.
   localparam int GRID_ROWS = (ROWS < 32) ? ROWS : 32;
   localparam int GRID_COLS = (COLS < 32) ? COLS : 32;

   localparam int COORD_W    = 5;
   localparam int ADDR_W     = 2 * COORD_W;
   localparam int CELL_DEPTH = 1 << ADDR_W;
   localparam int CELL_W     = 2;
   localparam int DEPTH_W    = 11;
   localparam int DIR_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int PRIO_W     = 8;

   localparam logic [PRIO_W-1:0]  PRIO_RESET = 8'd114;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX  = 11'd1024;

   // Bounds and coordinates one bit wider than a coordinate for compares.
   localparam logic [COORD_W:0]   GRID_ROWS_X = (COORD_W+1)'(GRID_ROWS);
   localparam logic [COORD_W:0]   GRID_COLS_X = (COORD_W+1)'(GRID_COLS);
   localparam logic [COORD_W-1:0] GOAL_ROW    = COORD_W'(GRID_ROWS - 2);
   localparam logic [COORD_W-1:0] GOAL_COL    = COORD_W'(GRID_COLS - 2);
   localparam logic [COORD_W-1:0] START_POS   = COORD_W'(1);

   // Cell codes.
   localparam logic [CELL_W-1:0] CELL_FREE  = 2'd0;
   localparam logic [CELL_W-1:0] CELL_DEAD  = 2'd1;
   localparam logic [CELL_W-1:0] CELL_TRAIL = 2'd2;
   localparam logic [CELL_W-1:0] CELL_BLOCK = 2'd3;

   // Direction codes.
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_LOADED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ADVANCED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BACKED   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_STUCK    = 2'd3;

   // Request action codes.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD_WR,
      S_RD0,
      S_RD1,
      S_RD2,
      S_RD3,
      S_CAP,
      S_EVAL,
      S_WR1,
      S_WR2,
      S_DONE
   } state_type;

   typedef struct packed {
      logic             accept;
      logic             rd_en;
      logic [DIR_W-1:0] rd_sel;
      logic             cap_en;
      logic [DIR_W-1:0] cap_sel;
      logic             eval;
      logic             wr_load;
      logic             wr_first;
      logic             wr_second;
      logic             rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] wr_count;
   } stat_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                    input logic [COORD_W-1:0] col);
      return {row, col};
   endfunction

endpackage

### src/gmd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module gmd_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### src/gmd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid maze DFS stepper controller
// Sequences request intake, the four neighbor reads, the decision, the cell
// writes and the hand-off to the result register.
// ----------------------------------------------------------------------------
module gmd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_action,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  gmd_pkg::stat_type stat,
   output gmd_pkg::cmd_type  cmd
);
   import gmd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_action == ACT_STEP) ? S_RD0 : S_LOAD_WR;
            end
         end
         S_LOAD_WR: state_in = S_DONE;
         S_RD0:     state_in = S_RD1;
         S_RD1:     state_in = S_RD2;
         S_RD2:     state_in = S_RD3;
         S_RD3:     state_in = S_CAP;
         S_CAP:     state_in = S_EVAL;
         S_EVAL:    state_in = S_WR1;
         S_WR1: begin
            if (stat.wr_count == 2'd0) begin
               state_in = S_DONE;
            end else if (stat.wr_count == 2'd2) begin
               state_in = S_WR2;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WR2:     state_in = S_DONE;
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         S_LOAD_WR: cmd.wr_load = 1'b1;
         S_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = DIR_UP;
         end
         S_RD1: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = DIR_DOWN;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = DIR_UP;
         end
         S_RD2: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = DIR_LEFT;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = DIR_DOWN;
         end
         S_RD3: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = DIR_RIGHT;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = DIR_LEFT;
         end
         S_CAP: begin
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = DIR_RIGHT;
         end
         S_EVAL: cmd.eval = 1'b1;
         S_WR1:  cmd.wr_first = (stat.wr_count != 2'd0);
         S_WR2:  cmd.wr_second = 1'b1;
         S_DONE: cmd.rsp_load = slot_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### src/gmd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid maze DFS stepper datapath
// Holds the walker position, path depth, goal flag and direction priority,
// the grid memory, the captured neighbor cells and the result register.
// ----------------------------------------------------------------------------
module gmd_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  gmd_pkg::cmd_type                 cmd,
   output gmd_pkg::stat_type                stat,
   input  logic                             csr_wr_en,
   input  logic [gmd_pkg::PRIO_W-1:0]       csr_wr_data,
   input  logic [gmd_pkg::COORD_W-1:0]      req_row,
   input  logic [gmd_pkg::COORD_W-1:0]      req_col,
   input  logic [gmd_pkg::CELL_W-1:0]       req_value,
   output logic [gmd_pkg::STATUS_W-1:0]     rsp_status,
   output logic [gmd_pkg::DIR_W-1:0]        rsp_dir,
   output logic [gmd_pkg::COORD_W-1:0]      rsp_row,
   output logic [gmd_pkg::COORD_W-1:0]      rsp_col,
   output logic                             rsp_goal,
   output logic [gmd_pkg::DEPTH_W-1:0]      rsp_depth
);
   import gmd_pkg::*;

   // Architectural state.
   logic [PRIO_W-1:0]  prio_ff;
   logic [COORD_W-1:0] cur_row_ff, cur_row_in;
   logic [COORD_W-1:0] cur_col_ff, cur_col_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               goal_ff, goal_in;

   // Per-item working registers.
   logic [COORD_W-1:0]  ld_row_ff, ld_col_ff;
   logic [CELL_W-1:0]   ld_val_ff;
   logic [CELL_W-1:0]   nb_ff [4];
   logic [ADDR_W-1:0]   wr1_addr_ff, wr2_addr_ff;
   logic [CELL_W-1:0]   wr1_val_ff;
   logic [1:0]          wr_count_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [DIR_W-1:0]    res_dir_ff;

   // Result register.
   logic [STATUS_W-1:0] out_status_ff;
   logic [DIR_W-1:0]    out_dir_ff;
   logic [COORD_W-1:0]  out_row_ff, out_col_ff;
   logic                out_goal_ff;
   logic [DEPTH_W-1:0]  out_depth_ff;

   // Neighbor geometry.
   logic [COORD_W-1:0] nbr_row [4];
   logic [COORD_W-1:0] nbr_col [4];
   logic [3:0]         nbr_in_grid;

   // Decision.
   logic [3:0]         is_free, is_trail;
   logic               any_free, adv_found, back_found;
   logic [DIR_W-1:0]   adv_dir, back_dir, prio_dir;
   logic [DIR_W-1:0]   move_dir;

   // Memory port.
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;
   logic              ld_in_grid;

   always_comb begin
      nbr_row[DIR_UP]    = cur_row_ff - COORD_W'(1);
      nbr_col[DIR_UP]    = cur_col_ff;
      nbr_row[DIR_DOWN]  = cur_row_ff + COORD_W'(1);
      nbr_col[DIR_DOWN]  = cur_col_ff;
      nbr_row[DIR_LEFT]  = cur_row_ff;
      nbr_col[DIR_LEFT]  = cur_col_ff - COORD_W'(1);
      nbr_row[DIR_RIGHT] = cur_row_ff;
      nbr_col[DIR_RIGHT] = cur_col_ff + COORD_W'(1);
      nbr_in_grid[DIR_UP]    = (cur_row_ff != '0);
      nbr_in_grid[DIR_DOWN]  = ({1'b0, cur_row_ff} + (COORD_W+1)'(1)) < GRID_ROWS_X;
      nbr_in_grid[DIR_LEFT]  = (cur_col_ff != '0);
      nbr_in_grid[DIR_RIGHT] = ({1'b0, cur_col_ff} + (COORD_W+1)'(1)) < GRID_COLS_X;
   end

   // Advance takes the first free neighbor in programmed priority order,
   // backtrack the first trail neighbor in fixed up, down, left, right order.
   always_comb begin
      adv_found  = 1'b0;
      adv_dir    = DIR_UP;
      back_found = 1'b0;
      back_dir   = DIR_UP;
      prio_dir   = DIR_UP;
      for (int d = 0; d < 4; d++) begin
         is_free[d]  = (nb_ff[d] == CELL_FREE);
         is_trail[d] = (nb_ff[d] == CELL_TRAIL);
      end
      any_free = |is_free;
      for (int k = 0; k < 4; k++) begin
         prio_dir = prio_ff[2*k +: 2];
         if (!adv_found && is_free[prio_dir]) begin
            adv_found = 1'b1;
            adv_dir   = prio_dir;
         end
      end
      for (int d = 3; d >= 0; d--) begin
         if (is_trail[d]) begin
            back_found = 1'b1;
            back_dir   = DIR_W'(d);
         end
      end
      move_dir = any_free ? adv_dir : back_dir;
   end

   assign ld_in_grid = ({1'b0, ld_row_ff} < GRID_ROWS_X) && ({1'b0, ld_col_ff} < GRID_COLS_X);

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = cell_addr(nbr_row[cmd.rd_sel], nbr_col[cmd.rd_sel]);
      ram_wdata = CELL_TRAIL;
      priority if (cmd.wr_load) begin
         ram_we    = ld_in_grid;
         ram_addr  = cell_addr(ld_row_ff, ld_col_ff);
         ram_wdata = ld_val_ff;
      end else if (cmd.wr_first) begin
         ram_we    = 1'b1;
         ram_addr  = wr1_addr_ff;
         ram_wdata = wr1_val_ff;
      end else if (cmd.wr_second) begin
         ram_we    = 1'b1;
         ram_addr  = wr2_addr_ff;
         ram_wdata = CELL_TRAIL;
      end
   end

   gmd_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELL_DEPTH)
   ) u_grid (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // Position, depth and goal flag updates.
   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      depth_in   = depth_ff;
      goal_in    = goal_ff;
      if (cmd.eval) begin
         if (any_free) begin
            if (adv_found) begin
               cur_row_in = nbr_row[adv_dir];
               cur_col_in = nbr_col[adv_dir];
               if (depth_ff < DEPTH_MAX) begin
                  depth_in = depth_ff + DEPTH_W'(1);
               end
            end
         end else begin
            if (depth_ff != '0) begin
               depth_in = depth_ff - DEPTH_W'(1);
            end
            if (back_found) begin
               cur_row_in = nbr_row[back_dir];
               cur_col_in = nbr_col[back_dir];
            end
         end
      end
      if (ram_we && (ram_addr == cell_addr(GOAL_ROW, GOAL_COL))) begin
         goal_in = (ram_wdata == CELL_TRAIL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_ff    <= PRIO_RESET;
         cur_row_ff <= START_POS;
         cur_col_ff <= START_POS;
         depth_ff   <= '0;
         goal_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            prio_ff <= csr_wr_data;
         end
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         depth_ff   <= depth_in;
         goal_ff    <= goal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ld_row_ff     <= req_row;
         ld_col_ff     <= req_col;
         ld_val_ff     <= req_value;
         res_status_ff <= ST_LOADED;
         res_dir_ff    <= DIR_UP;
         wr_count_ff   <= 2'd0;
      end
      if (cmd.cap_en) begin
         nb_ff[cmd.cap_sel] <= nbr_in_grid[cmd.cap_sel] ? ram_rdata : CELL_BLOCK;
      end
      if (cmd.eval) begin
         wr1_addr_ff <= cell_addr(cur_row_ff, cur_col_ff);
         wr1_val_ff  <= CELL_DEAD;
         wr2_addr_ff <= cell_addr(cur_row_ff, cur_col_ff);
         res_dir_ff  <= DIR_UP;
         res_status_ff <= ST_STUCK;
         wr_count_ff <= 2'd0;
         if (any_free ? adv_found : back_found) begin
            res_dir_ff <= move_dir;
         end
         if (any_free && adv_found) begin
            wr1_addr_ff   <= cell_addr(nbr_row[adv_dir], nbr_col[adv_dir]);
            wr1_val_ff    <= CELL_TRAIL;
            res_status_ff <= ST_ADVANCED;
            wr_count_ff   <= 2'd2;
         end else if (!any_free && back_found) begin
            res_status_ff <= ST_BACKED;
            wr_count_ff   <= 2'd1;
         end
      end
      if (cmd.rsp_load) begin
         out_status_ff <= res_status_ff;
         out_dir_ff    <= res_dir_ff;
         out_row_ff    <= cur_row_ff;
         out_col_ff    <= cur_col_ff;
         out_goal_ff   <= goal_ff;
         out_depth_ff  <= depth_ff;
      end
   end

   assign stat.wr_count = wr_count_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_dir       = out_dir_ff;
   assign rsp_row       = out_row_ff;
   assign rsp_col       = out_col_ff;
   assign rsp_goal      = out_goal_ff;
   assign rsp_depth     = out_depth_ff;

endmodule

### src/grid_maze_dfs_stepper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid maze DFS stepper core
// Sequence: a load request writes its one cell; a step request runs the four
// neighbor reads, capture, decision, one write slot plus a second write for
// an advance. A new request is taken only once the previous one has been
// handed to the result register. The single-port grid memory serves every
// neighbor read and cell write; a finished item waits while the result
// register still holds an unaccepted response.
// Reset (synchronous, active high): walker at (1,1), depth 0, priority 114;
// the grid memory is not cleared and holds undefined cells until written.
// ----------------------------------------------------------------------------
module grid_maze_dfs_stepper_core (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cell_row[4:0], cell_col[9:5], cell_value[11:10], zero
   input  logic        req_tuser,   // action: 0 load one cell, 1 take one walk step
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // move_dir[1:0], walker_row[6:2], walker_col[11:7],
                                    // goal_reached[12], path_depth[23:13]
   output logic [1:0]  rsp_tuser,   // status: 0 loaded, 1 advanced, 2 backtracked, 3 stuck
   // Direction priority register.
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import gmd_pkg::*;

   cmd_type             cmd;
   stat_type            stat;
   logic [DIR_W-1:0]    rsp_dir;
   logic [COORD_W-1:0]  rsp_row, rsp_col;
   logic                rsp_goal;
   logic [DEPTH_W-1:0]  rsp_depth;

   // The controller owns the handshakes and the sequence of memory accesses;
   // the response register sits in the datapath so a new request can be taken
   // while a finished response still waits downstream.
   gmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_action(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the walker state, the grid memory and the decision
   // logic that chooses between advancing, backtracking and reporting stuck.
   gmd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_row    (req_tdata[4:0]),
      .req_col    (req_tdata[9:5]),
      .req_value  (req_tdata[11:10]),
      .rsp_status (rsp_tuser),
      .rsp_dir    (rsp_dir),
      .rsp_row    (rsp_row),
      .rsp_col    (rsp_col),
      .rsp_goal   (rsp_goal),
      .rsp_depth  (rsp_depth)
   );

   // Response fields are packed from the lowest bit up.
   assign rsp_tdata = {rsp_depth, rsp_goal, rsp_col, rsp_row, rsp_dir};

endmodule

### verif/maze_walk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze walk checker
// Watches the request, response and priority ports of the maze stepper. It
// keeps its own grid, walker and path depth, predicts one response per
// accepted request and compares the responses in order, field by field.
// ----------------------------------------------------------------------------
module maze_walk_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [15:0]                 req_tdata,
   input  logic                        req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [23:0]                 rsp_tdata,
   input  logic [1:0]                  rsp_tuser,
   input  logic                        csr_wr_en,
   input  logic [7:0]                  csr_wr_data,
   output int                          mismatch_count,
   output int                          pending_count,
   output logic [gmd_pkg::COORD_W-1:0] predicted_row,
   output logic [gmd_pkg::COORD_W-1:0] predicted_col
);
   import gmd_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DIR_W-1:0]    move_dir;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic                goal;
      logic [DEPTH_W-1:0]  depth;
   } walk_result_type;

   logic [CELL_W-1:0]  maze_grid [GRID_ROWS][GRID_COLS];
   logic [COORD_W-1:0] walk_row;
   logic [COORD_W-1:0] walk_col;
   logic [DEPTH_W-1:0] walk_depth;
   logic [PRIO_W-1:0]  dir_order;
   walk_result_type    expected_walks [$];

   function automatic int row_step(input logic [DIR_W-1:0] dir);
      if (dir == DIR_UP) return -1;
      if (dir == DIR_DOWN) return 1;
      return 0;
   endfunction

   function automatic int col_step(input logic [DIR_W-1:0] dir);
      if (dir == DIR_LEFT) return -1;
      if (dir == DIR_RIGHT) return 1;
      return 0;
   endfunction

   // Cells beyond the grid read as blocked, so they are never free or trail.
   function automatic logic [CELL_W-1:0] cell_look(input int r, input int c);
      if (r < 0 || c < 0 || r >= GRID_ROWS || c >= GRID_COLS) return CELL_BLOCK;
      return maze_grid[r][c];
   endfunction

   task automatic predict_walk(input logic act, input logic [COORD_W-1:0] ld_row,
                               input logic [COORD_W-1:0] ld_col,
                               input logic [CELL_W-1:0] ld_val,
                               output walk_result_type res);
      int r, c, nr, nc;
      logic any_free, moved;
      logic [DIR_W-1:0] dir;
      res          = '0;
      res.status   = ST_LOADED;
      res.move_dir = DIR_UP;
      if (act == ACT_LOAD) begin
         if (ld_row < GRID_ROWS && ld_col < GRID_COLS) maze_grid[ld_row][ld_col] = ld_val;
      end else begin
         r        = walk_row;
         c        = walk_col;
         any_free = 1'b0;
         moved    = 1'b0;
         for (int d = 0; d < 4; d++) begin
            dir = DIR_W'(d);
            if (cell_look(r + row_step(dir), c + col_step(dir)) == CELL_FREE) any_free = 1'b1;
         end
         if (any_free) begin
            // Only the listed directions are tried; a free cell elsewhere is ignored.
            for (int k = 0; k < 4 && !moved; k++) begin
               dir = dir_order[2*k +: 2];
               nr  = r + row_step(dir);
               nc  = c + col_step(dir);
               if (cell_look(nr, nc) == CELL_FREE) begin
                  maze_grid[nr][nc] = CELL_TRAIL;
                  maze_grid[r][c]   = CELL_TRAIL;
                  walk_row = COORD_W'(nr);
                  walk_col = COORD_W'(nc);
                  if (walk_depth < DEPTH_MAX) walk_depth++;
                  res.status   = ST_ADVANCED;
                  res.move_dir = dir;
                  moved        = 1'b1;
               end
            end
         end else begin
            // The pop happens even when no trail neighbor is found afterwards.
            if (walk_depth != '0) walk_depth--;
            for (int k = 0; k < 4 && !moved; k++) begin
               dir = DIR_W'(k);
               nr  = r + row_step(dir);
               nc  = c + col_step(dir);
               if (cell_look(nr, nc) == CELL_TRAIL) begin
                  maze_grid[r][c] = CELL_DEAD;
                  walk_row = COORD_W'(nr);
                  walk_col = COORD_W'(nc);
                  res.status   = ST_BACKED;
                  res.move_dir = dir;
                  moved        = 1'b1;
               end
            end
         end
         if (!moved) res.status = ST_STUCK;
      end
      res.row   = walk_row;
      res.col   = walk_col;
      res.goal  = (maze_grid[GOAL_ROW][GOAL_COL] == CELL_TRAIL);
      res.depth = walk_depth;
   endtask

   always @(posedge clock) begin : watch
      walk_result_type seen;
      walk_result_type want;
      if (reset) begin
         walk_row       = START_POS;
         walk_col       = START_POS;
         walk_depth     = '0;
         dir_order      = PRIO_RESET;
         mismatch_count = 0;
         expected_walks.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status   = rsp_tuser;
            seen.move_dir = rsp_tdata[1:0];
            seen.row      = rsp_tdata[6:2];
            seen.col      = rsp_tdata[11:7];
            seen.goal     = rsp_tdata[12];
            seen.depth    = rsp_tdata[23:13];
            if (expected_walks.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] response with no request outstanding: tuser=%0d tdata=%h",
                           $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_walks.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("[%0t] response mismatch: expected status=%0d dir=%0d %s",
                              $time, want.status, want.move_dir, "and position below");
                     $display("   expected row=%0d col=%0d goal=%0d depth=%0d",
                              want.row, want.col, want.goal, want.depth);
                     $display("   got status=%0d dir=%0d row=%0d col=%0d goal=%0d depth=%0d",
                              seen.status, seen.move_dir, seen.row, seen.col,
                              seen.goal, seen.depth);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_walk(req_tuser, req_tdata[4:0], req_tdata[9:5], req_tdata[11:10], want);
            expected_walks.insert(expected_walks.size(), want);
         end
         if (csr_wr_en) dir_order = csr_wr_data;
      end
      pending_count = expected_walks.size();
      predicted_row = walk_row;
      predicted_col = walk_col;
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze stepper testbench
// Drives load and step requests into the grid maze DFS stepper, programs the
// direction priority between phases and leaves all response checking to the
// maze walk checker, whose mismatch and pending counts decide the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import gmd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // cell_row[4:0], cell_col[9:5], cell_value[11:10], zero
   logic        req_tuser;   // action: 0 load one cell, 1 take one walk step
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // move_dir[1:0], walker_row[6:2], walker_col[11:7],
                             // goal_reached[12], path_depth[23:13]
   logic [1:0]  rsp_tuser;   // status: 0 loaded, 1 advanced, 2 backtracked, 3 stuck
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   int                 mismatch_count;
   int                 pending_count;
   logic [COORD_W-1:0] predicted_row;
   logic [COORD_W-1:0] predicted_col;

   // Sender burst state and the request for the long receiver hold-off.
   int   burst_left = 0;
   logic steady     = 1'b0;
   logic hold_go    = 1'b0;

   // Cells loaded so far. A cell is only made enterable once all of its
   // neighbors inside the grid are loaded, so the walker never looks at a
   // cell that was never written.
   bit written_map [GRID_ROWS][GRID_COLS];

   grid_maze_dfs_stepper_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   maze_walk_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .predicted_row  (predicted_row),
      .predicted_col  (predicted_col)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Offer one request and return at the falling edge after it is accepted.
   // The valid stays high into the next request unless a gap starts, so
   // back-to-back requests never see a low pulse on tvalid.
   task automatic send_request(input logic act, input logic [COORD_W-1:0] row,
                               input logic [COORD_W-1:0] col,
                               input logic [CELL_W-1:0] val);
      int gap;
      if (burst_left <= 0) begin
         gap = steady ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tuser  = act;
      req_tdata  = {4'b0000, val, col, row};
      req_tvalid = 1'b1;
      if (act == ACT_LOAD) written_map[row][col] = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   // A step carries random load fields, which the block must ignore.
   task automatic take_step();
      send_request(ACT_STEP, COORD_W'($urandom_range(0, 31)), COORD_W'($urandom_range(0, 31)),
                   CELL_W'($urandom_range(0, 3)));
   endtask

   // Stop offering requests until every outstanding response has come back.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // The priority register is written only while the block is idle.
   task automatic write_priority(input logic [PRIO_W-1:0] prio);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = prio;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // Mostly free cells so walks run deep, with some walls and a few
   // pre-marked dead and trail cells.
   function automatic logic [CELL_W-1:0] random_cell();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 13) return CELL_FREE;
      if (pick < 17) return CELL_BLOCK;
      if (pick == 17) return CELL_DEAD;
      return CELL_TRAIL;
   endfunction

   // True when every neighbor of the cell that lies inside the grid is loaded.
   function automatic logic neighbors_written(input int r, input int c);
      if (r > 0 && !written_map[r-1][c]) return 1'b0;
      if (r < GRID_ROWS - 1 && !written_map[r+1][c]) return 1'b0;
      if (c > 0 && !written_map[r][c-1]) return 1'b0;
      if (c < GRID_COLS - 1 && !written_map[r][c+1]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic load_cell(input int r, input int c, input logic [CELL_W-1:0] v);
      send_request(ACT_LOAD, COORD_W'(r), COORD_W'(c), v);
   endtask

   // Load one value into every cell of a rectangle, row by row.
   task automatic load_box(input int r_lo, input int r_hi, input int c_lo, input int c_hi,
                           input logic [CELL_W-1:0] v);
      for (int r = r_lo; r <= r_hi; r++) begin
         for (int c = c_lo; c <= c_hi; c++) begin
            load_cell(r, c, v);
         end
      end
   endtask

   // Random cell value; a free or trail cell next to an unloaded cell is
   // turned into a wall instead.
   task automatic load_guarded(input int r, input int c);
      logic [CELL_W-1:0] v;
      v = random_cell();
      if ((v == CELL_FREE || v == CELL_TRAIL) && !neighbors_written(r, c)) v = CELL_BLOCK;
      load_cell(r, c, v);
   endtask

   // Stimulus: directed corner cases first, then a corridor walk through the
   // goal cell and finally randomized maze patches and walks.
   initial begin : stimulus
      int random_items;
      int span;
      int steps;
      int r0, c0;
      logic [PRIO_W-1:0] prio;
      random_items = 0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = ACT_LOAD;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The goal cell goes first, because every response reports it. Then
      // wall off the corner around the start. With the walker boxed in at
      // depth zero a step pops an empty path and reports stuck.
      steady = 1'b1;
      load_cell(int'(GOAL_ROW), int'(GOAL_COL), CELL_BLOCK);
      load_box(0, 2, 0, 5, CELL_BLOCK);
      steady = 1'b0;
      take_step();
      // Open the cell to the right; the reset priority reaches it.
      load_cell(1, 2, CELL_FREE);
      take_step();
      // A free cell to the right, but the priority only lists up: stuck.
      load_cell(1, 3, CELL_FREE);
      write_priority({DIR_UP, DIR_UP, DIR_UP, DIR_UP});
      take_step();
      write_priority({DIR_RIGHT, DIR_RIGHT, DIR_RIGHT, DIR_RIGHT});
      take_step();
      // Dead end: back along the trail twice, then stuck at depth zero.
      take_step();
      take_step();
      take_step();
      // Goal flag follows the trail mark on the goal cell.
      load_cell(int'(GOAL_ROW), int'(GOAL_COL), CELL_TRAIL);
      load_cell(0, 0, CELL_DEAD);
      load_cell(int'(GOAL_ROW), int'(GOAL_COL), CELL_BLOCK);

      // Walled corridor along row 1 and down the next-to-last column. With
      // down first, then right, the walker runs from the start into the goal
      // cell at the end of the corridor and then backs out of that dead end.
      write_priority({DIR_UP, DIR_LEFT, DIR_RIGHT, DIR_DOWN});
      load_box(0, 0, 0, GRID_COLS - 1, CELL_BLOCK);
      load_box(1, GRID_ROWS - 1, GRID_COLS - 1, GRID_COLS - 1, CELL_BLOCK);
      load_box(2, 2, 0, GRID_COLS - 3, CELL_BLOCK);
      load_box(3, GRID_ROWS - 1, GRID_COLS - 3, GRID_COLS - 3, CELL_BLOCK);
      load_cell(GRID_ROWS - 1, GRID_COLS - 2, CELL_BLOCK);
      load_cell(1, 0, CELL_BLOCK);
      load_box(1, 1, 1, GRID_COLS - 2, CELL_FREE);
      load_box(2, GRID_ROWS - 2, GRID_COLS - 2, GRID_COLS - 2, CELL_FREE);
      // The receiver now holds off for a long stretch while steps keep coming.
      hold_go = 1'b1;
      repeat (70) take_step();

      // Random part: reshape a patch around the walker, then walk it with
      // an occasional stray load thrown in.
      while (random_items < 600) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0:       prio = 8'h00;
               1:       prio = 8'hFF;
               2:       prio = PRIO_RESET;
               default: prio = PRIO_W'($urandom_range(0, 255));
            endcase
            write_priority(prio);
         end else if ($urandom_range(0, 4) == 0) begin
            wait_drained();
         end
         span = $urandom_range(1, 3);
         r0   = predicted_row;
         c0   = predicted_col;
         for (int dr = -span; dr <= span; dr++) begin
            for (int dc = -span; dc <= span; dc++) begin
               if (r0 + dr >= 0 && r0 + dr < GRID_ROWS && c0 + dc >= 0 &&
                   c0 + dc < GRID_COLS) begin
                  load_guarded(r0 + dr, c0 + dc);
                  random_items++;
               end
            end
         end
         steps = $urandom_range(10, 50);
         for (int i = 0; i < steps; i++) begin
            if ($urandom_range(0, 9) == 0)
               load_guarded($urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1));
            else
               take_step();
            random_items++;
         end
      end

      // Let every response arrive, then allow a few more cycles so that a
      // stray extra response would still be caught by the checker.
      wait_drained();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Receiver: the stall pattern switches between always ready, coin flips,
   // rare ready and a fixed duty cycle. Once, when the stimulus asks for it,
   // it holds off while the sender keeps offering requests, so the block backs
   // up and drops its request ready.
   initial begin : receiver
      int   mode;
      int   tick;
      logic long_hold_done;
      mode           = 0;
      tick           = 0;
      long_hold_done = 1'b0;
      rsp_tready     = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (!long_hold_done && hold_go) begin
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
            long_hold_done = 1'b1;
         end else if ($urandom_range(0, 2999) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(50, 200)) @(negedge clock);
         end
         if (tick % 32 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = $urandom_range(0, 1);
            2:       rsp_tready = ($urandom_range(0, 3) == 0);
            default: rsp_tready = ((tick & 4) != 0);
         endcase
      end
   end

   // Run limit, far beyond the slowest passing run.
   initial begin : run_limit
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
